FILE: design/crc16_frame_deframer_macros.svh
// assertion macros for the crc16 frame deframer
// included by the modules that carry concurrent assertions
`ifndef CRC16_FRAME_DEFRAMER_MACROS_SVH
`define CRC16_FRAME_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle property, held off during reset
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent this cycle, consequent in the next cycle
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/cfd_pkg.sv
// shared types, codes and the byte-wide crc update for the frame deframer
// no dependencies
package cfd_pkg;

    localparam int PAYLOAD_LIMIT_DEF = 512;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // item kinds on the input side
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // reject reasons
    localparam logic [1:0] RSN_CRC      = 2'd0;
    localparam logic [1:0] RSN_SYNC2    = 2'd1;
    localparam logic [1:0] RSN_TOO_LONG = 2'd2;
    localparam logic [1:0] RSN_TIMEOUT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd2;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd3;

    localparam logic [9:0]  MAX_PAYLOAD_RST = 10'd272;
    localparam logic [15:0] TIMEOUT_RST     = 16'd50;
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'hAA;

    typedef struct packed {
        logic [9:0]  max_payload;
        logic [15:0] timeout_ticks;
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [8:0] position;
        logic [7:0] command;
        logic [7:0] sequence_res;
        logic [9:0] length;
        logic [1:0] reason;
    } res_t;

    // crc-16/ccitt-false, one byte, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // header length clipped to the 10-bit result field
    function automatic logic [9:0] len_sat(input logic [15:0] len);
        return (len > 16'd1023) ? 10'd1023 : len[9:0];
    endfunction

endpackage

FILE: design/crc16_frame_deframer.sv
// top level of the sync/length/crc-16 frame deframer
// depends on cfd_pkg, cfd_cfg_regs, cfd_parser, cfd_out_buf
//
// usage
// - input channel (in_valid / in_stall): one item per handshake, func selects a
//   received byte (rx_byte) or one time tick
// - output channel (out_valid / out_stall): at most one result item per input
//   item: a payload byte with its position, or a frame verdict (accept, or
//   reject with a reason code), tagged with command, sequence and, once known, length
// - config port: cfg_we with cfg_index 0..3 writes max_payload, timeout_ticks,
//   sync_first, sync_second; write only while no item is in flight
// - results are registered into the head register, or the skid if head is held
// - throughput: one item per cycle while in_stall is low, set by the byte-wide
//   crc update and the phase register
// - stall: results queue in a head register and a one-deep skid register; the
//   input stalls only while the skid register is occupied
// - reset: phase returns to sync hunt, crc to 0xffff, config to its defaults,
//   both result registers empty; no clearing pass
module crc16_frame_deframer #(
    parameter int PAYLOAD_LIMIT = cfd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [8:0]  position,
    output logic [7:0]  command,
    output logic [7:0]  sequence_res,
    output logic [9:0]  length,
    output logic [1:0]  reason
);
    import cfd_pkg::*;

    cfg_t  cfg;
    res_t  res;
    res_t  head;
    logic  res_valid;
    logic  buf_full;
    logic  accept;

    // stall comes from a register, so in_stall has no path from out_stall
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    cfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // all frame state updates at the edge that takes the item
    cfd_parser #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .func      (func),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register with skid stage
    cfd_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind         = head.kind;
    assign data_byte    = head.data_byte;
    assign position     = head.position;
    assign command      = head.command;
    assign sequence_res = head.sequence_res;
    assign length       = head.length;
    assign reason       = head.reason;

endmodule

FILE: design/cfd_cfg_regs.sv
// configuration registers of the frame deframer
// depends on cfd_pkg
module cfd_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output cfd_pkg::cfg_t   cfg
);
    import cfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_PAYLOAD: cfg_next.max_payload   = cfg_data[9:0];
                CFG_TIMEOUT:     cfg_next.timeout_ticks = cfg_data;
                CFG_SYNC_FIRST:  cfg_next.sync_first    = cfg_data[7:0];
                CFG_SYNC_SECOND: cfg_next.sync_second   = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload   <= MAX_PAYLOAD_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.sync_first    <= SYNC_FIRST_RST;
            cfg_reg.sync_second   <= SYNC_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/cfd_parser.sv
// frame state machine: sync hunt, header, payload, crc check, timeout
// depends on cfd_pkg and the assertion macro header
`include "crc16_frame_deframer_macros.svh"

module cfd_parser #(
    parameter int PAYLOAD_LIMIT = cfd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfd_pkg::cfg_t   cfg,
    input  logic            accept,
    input  logic            func,
    input  logic [7:0]      rx_byte,
    output logic            res_valid,
    output cfd_pkg::res_t   res
);
    import cfd_pkg::*;

    localparam int BCW = $clog2(PAYLOAD_LIMIT + 1);
    localparam logic [16:0] LIMIT_P = 17'(PAYLOAD_LIMIT);

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_HEADER  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_CRCLO   = 6'b010000,
        PH_CRCHI   = 6'b100000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [1:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [7:0]      seq_reg, seq_next;
    logic [15:0]     len_reg, len_next;
    logic [BCW-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      crc_lo_reg, crc_lo_next;
    logic [15:0]     idle_reg, idle_next;

    logic            in_frame;
    logic [15:0]     idle_inc;
    logic [15:0]     crc_upd;
    logic [15:0]     len_new;
    logic [16:0]     limit;
    logic [BCW-1:0]  byte_cnt_inc;
    logic            have_len;
    logic [15:0]     len_src;
    logic [1:0]      kind_o;
    logic [1:0]      reason_o;
    logic            payload_o;

    assign in_frame = (phase_reg == PH_SYNC2) || (phase_reg == PH_HEADER) ||
                      (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CRCLO) ||
                      (phase_reg == PH_CRCHI);
    assign idle_inc = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign crc_upd  = crc_feed(crc_reg, rx_byte);
    assign len_new  = {rx_byte, crc_lo_reg};
    assign limit    = ({7'd0, cfg.max_payload} < LIMIT_P) ? {7'd0, cfg.max_payload} : LIMIT_P;
    assign byte_cnt_inc = byte_cnt_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        cmd_next      = cmd_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        byte_cnt_next = byte_cnt_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        have_len      = 1'b0;
        len_src       = len_reg;
        kind_o        = KIND_PAYLOAD;
        reason_o      = RSN_CRC;
        payload_o     = 1'b0;
        if (accept)
        begin
            if (func == FUNC_TICK)
            begin
                if (in_frame)
                begin
                    if (idle_inc >= cfg.timeout_ticks)
                    begin
                        res_valid  = 1'b1;
                        kind_o     = KIND_REJECT;
                        reason_o   = RSN_TIMEOUT;
                        have_len   = (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CRCLO) ||
                                     (phase_reg == PH_CRCHI);
                        phase_next = PH_HUNT;
                        idle_next  = 16'd0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else
            begin
                idle_next = 16'd0;
                unique case (phase_reg)
                    PH_SYNC2:
                    begin
                        if (rx_byte != cfg.sync_second)
                        begin
                            res_valid  = 1'b1;
                            kind_o     = KIND_REJECT;
                            reason_o   = RSN_SYNC2;
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            phase_next   = PH_HEADER;
                            hdr_cnt_next = 2'd0;
                        end
                    end
                    PH_HEADER:
                    begin
                        crc_next = crc_upd;
                        case (hdr_cnt_reg)
                            2'd0: cmd_next    = rx_byte;
                            2'd1: seq_next    = rx_byte;
                            2'd2: crc_lo_next = rx_byte;
                            default: ;
                        endcase
                        if (hdr_cnt_reg == 2'd3)
                        begin
                            len_next      = len_new;
                            hdr_cnt_next  = 2'd0;
                            byte_cnt_next = '0;
                            if ({1'b0, len_new} > limit)
                            begin
                                res_valid  = 1'b1;
                                kind_o     = KIND_REJECT;
                                reason_o   = RSN_TOO_LONG;
                                have_len   = 1'b1;
                                len_src    = len_new;
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                phase_next = (len_new == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 2'd1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next      = crc_upd;
                        byte_cnt_next = byte_cnt_inc;
                        if (16'(byte_cnt_inc) >= len_reg)
                        begin
                            phase_next = PH_CRCLO;
                        end
                        res_valid = 1'b1;
                        kind_o    = KIND_PAYLOAD;
                        have_len  = 1'b1;
                        payload_o = 1'b1;
                    end
                    PH_CRCLO:
                    begin
                        crc_lo_next = rx_byte;
                        phase_next  = PH_CRCHI;
                    end
                    PH_CRCHI:
                    begin
                        res_valid  = 1'b1;
                        have_len   = 1'b1;
                        phase_next = PH_HUNT;
                        if (len_new == crc_reg)
                        begin
                            kind_o = KIND_ACCEPT;
                        end
                        else
                        begin
                            kind_o   = KIND_REJECT;
                            reason_o = RSN_CRC;
                        end
                    end
                    default:
                    begin
                        // hunting, and any stray phase code
                        if (rx_byte == cfg.sync_first)
                        begin
                            phase_next    = PH_SYNC2;
                            hdr_cnt_next  = 2'd0;
                            cmd_next      = 8'd0;
                            seq_next      = 8'd0;
                            len_next      = 16'd0;
                            byte_cnt_next = '0;
                            crc_next      = CRC_INIT;
                            crc_lo_next   = 8'd0;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.kind         = kind_o;
        res.data_byte    = payload_o ? rx_byte : 8'd0;
        res.position     = payload_o ? 9'(byte_cnt_reg) : 9'd0;
        res.command      = cmd_reg;
        res.sequence_res = seq_reg;
        res.length       = have_len ? len_sat(len_src) : 10'd0;
        res.reason       = reason_o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            hdr_cnt_reg  <= 2'd0;
            cmd_reg      <= 8'd0;
            seq_reg      <= 8'd0;
            len_reg      <= 16'd0;
            byte_cnt_reg <= '0;
            crc_reg      <= CRC_INIT;
            crc_lo_reg   <= 8'd0;
            idle_reg     <= 16'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            cmd_reg      <= cmd_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            byte_cnt_reg <= byte_cnt_next;
            crc_reg      <= crc_next;
            crc_lo_reg   <= crc_lo_next;
            idle_reg     <= idle_next;
        end
    end

    // idle counter only runs inside a frame
    `CFD_ASSERT(a_hunt_idle_clear, clk, rst_n, (phase_reg != PH_HUNT) || (idle_reg == 16'd0), "idle ticks counted while hunting")
    // payload counter never passes the header length
    `CFD_ASSERT(a_count_in_length, clk, rst_n, (phase_reg != PH_PAYLOAD) || (16'(byte_cnt_reg) < len_reg), "payload count beyond length")
    // exactly one phase bit set
    `CFD_ASSERT(a_phase_onehot, clk, rst_n, $onehot(phase_reg), "phase register not one-hot")

endmodule

FILE: design/cfd_out_buf.sv
// two-entry result buffer: head register plus skid register
// depends on cfd_pkg and the assertion macro header
`include "crc16_frame_deframer_macros.svh"

module cfd_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfd_pkg::res_t   push_data,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output cfd_pkg::res_t   head
);
    import cfd_pkg::*;

    logic  head_valid_reg, head_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    res_t  head_reg, head_next;
    res_t  skid_reg, skid_next;
    logic  pop;

    assign pop = head_valid_reg && !out_stall;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // input side is stalled, so no push here
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign head      = head_reg;

    `CFD_ASSERT(a_skid_needs_head, clk, rst_n, !skid_valid_reg || head_valid_reg, "skid entry without head entry")
    `CFD_ASSERT_NEXT(a_skid_refills, clk, rst_n, skid_valid_reg, head_valid_reg, "head lost while skid entry pending")
    `CFD_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !skid_valid_reg, head_valid_reg, "pushed item dropped")

endmodule

FILE: dv/crc16_frame_deframer_tb.sv
// self-checking testbench for the crc16 frame deframer: streams bytes and ticks,
// predicts every payload byte and frame verdict, and checks them in order
// depends on cfd_pkg and crc16_frame_deframer
`timescale 1ns / 1ps

module crc16_frame_deframer_tb;

    import cfd_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 50;

    // receiver phases, in the order the frame walks through them
    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_HEADER  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_CRC_LO  = 6'b010000,
        PH_CRC_HI  = 6'b100000
    } rx_phase_t;

    // one input item as the sender holds it
    typedef struct packed {
        logic       f;
        logic [7:0] b;
    } rx_item_t;

    // clock, reset and dut ports; the dut inputs are known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = FUNC_BYTE;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [8:0]  position;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [9:0]  length;
    logic [1:0]  reason;

    // shadow of the configuration registers
    logic [9:0]  cfg_max = MAX_PAYLOAD_RST;
    logic [15:0] cfg_timeout = TIMEOUT_RST;
    logic [7:0]  cfg_sf = SYNC_FIRST_RST;
    logic [7:0]  cfg_ss = SYNC_SECOND_RST;

    // predicted receiver state
    rx_phase_t   rx_phase = PH_HUNT;
    logic [1:0]  hdr_cnt = '0;
    logic [7:0]  cmd_q = '0;
    logic [7:0]  seq_q = '0;
    logic [15:0] len_q = '0;
    logic [15:0] pay_cnt = '0;
    logic [15:0] crc_q = 16'hFFFF;
    logic [7:0]  crc_lo_q = '0;
    logic [15:0] idle_q = '0;

    // items waiting for the sender and results waiting for the dut
    rx_item_t pending_items[$];
    res_t     expected_results[$];

    int  err_count = 0;
    int  items_queued = 0;
    int  cycle_count = 0;
    bit  item_taken = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_cnt = 0;
    int  stall_mode = 0;

    crc16_frame_deframer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .position     (position),
        .command      (command),
        .sequence_res (sequence_res),
        .length       (length),
        .reason       (reason)
    );

    always #5 clk = ~clk;

    // crc-16/ccitt-false, one data bit at a time, msb first
    function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ 16'h1021;
        end
        return c;
    endfunction

    // effective payload limit: register clipped by the build limit
    function automatic int payload_cap();
        return (cfg_max < PAYLOAD_LIMIT_DEF) ? int'(cfg_max) : PAYLOAD_LIMIT_DEF;
    endfunction

    // result item tagged with the current header fields
    function automatic res_t tag_result(input logic [1:0] k, input logic [7:0] d,
                                        input logic [8:0] pos, input logic [1:0] rsn,
                                        input bit have_len);
        res_t r;
        r.kind = k;
        r.data_byte = d;
        r.position = pos;
        r.command = cmd_q;
        r.sequence_res = seq_q;
        r.length = !have_len ? 10'd0 : (len_q > 16'd1023 ? 10'd1023 : len_q[9:0]);
        r.reason = rsn;
        return r;
    endfunction

    // advance the predicted receiver by one accepted item
    task automatic deframe_step(input logic f, input logic [7:0] b);
        res_t       r;
        bit         has;
        logic [8:0] pos;
        has = 1'b0;
        if (f == FUNC_TICK)
        begin
            // ticks only count inside a frame
            if (rx_phase != PH_HUNT)
            begin
                if (idle_q != 16'hFFFF)
                    idle_q = idle_q + 16'd1;
                if (idle_q >= cfg_timeout)
                begin
                    r = tag_result(KIND_REJECT, 8'd0, 9'd0, RSN_TIMEOUT,
                                   rx_phase >= PH_PAYLOAD);
                    has = 1'b1;
                    rx_phase = PH_HUNT;
                    idle_q = '0;
                end
            end
        end
        else
        begin
            idle_q = '0;
            case (rx_phase)
                PH_SYNC2:
                begin
                    // a wrong second sync byte is eaten, never taken as a new first sync
                    if (b != cfg_ss)
                    begin
                        r = tag_result(KIND_REJECT, 8'd0, 9'd0, RSN_SYNC2, 1'b0);
                        has = 1'b1;
                        rx_phase = PH_HUNT;
                    end
                    else
                    begin
                        rx_phase = PH_HEADER;
                        hdr_cnt = '0;
                    end
                end
                PH_HEADER:
                begin
                    crc_q = ccitt_update(crc_q, b);
                    if (hdr_cnt == 2'd3)
                    begin
                        len_q = {b, crc_lo_q};
                        hdr_cnt = '0;
                        pay_cnt = '0;
                        if (int'(len_q) > payload_cap())
                        begin
                            r = tag_result(KIND_REJECT, 8'd0, 9'd0, RSN_TOO_LONG, 1'b1);
                            has = 1'b1;
                            rx_phase = PH_HUNT;
                        end
                        else
                            rx_phase = (len_q == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                    else
                    begin
                        case (hdr_cnt)
                            2'd0: cmd_q = b;
                            2'd1: seq_q = b;
                            default: crc_lo_q = b;
                        endcase
                        hdr_cnt = hdr_cnt + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    pos = pay_cnt[8:0];
                    crc_q = ccitt_update(crc_q, b);
                    pay_cnt = pay_cnt + 16'd1;
                    if (pay_cnt >= len_q)
                        rx_phase = PH_CRC_LO;
                    r = tag_result(KIND_PAYLOAD, b, pos, RSN_CRC, 1'b1);
                    has = 1'b1;
                end
                PH_CRC_LO:
                begin
                    crc_lo_q = b;
                    rx_phase = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    // received crc is little-endian
                    if ({b, crc_lo_q} == crc_q)
                        r = tag_result(KIND_ACCEPT, 8'd0, 9'd0, RSN_CRC, 1'b1);
                    else
                        r = tag_result(KIND_REJECT, 8'd0, 9'd0, RSN_CRC, 1'b1);
                    has = 1'b1;
                    rx_phase = PH_HUNT;
                end
                default:
                begin
                    // hunting: a first sync byte opens a fresh frame
                    if (b == cfg_sf)
                    begin
                        rx_phase = PH_SYNC2;
                        hdr_cnt = '0;
                        cmd_q = '0;
                        seq_q = '0;
                        len_q = '0;
                        pay_cnt = '0;
                        crc_q = 16'hFFFF;
                        crc_lo_q = '0;
                    end
                end
            endcase
        end
        if (has)
            expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // register write through the plain write port, only while idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_PAYLOAD: cfg_max = val[9:0];
            CFG_TIMEOUT:     cfg_timeout = val;
            CFG_SYNC_FIRST:  cfg_sf = val[7:0];
            default:         cfg_ss = val[7:0];
        endcase
    endtask

    task automatic set_config(input logic [9:0] mx, input logic [15:0] to,
                              input logic [7:0] sf, input logic [7:0] ss);
        write_reg(CFG_MAX_PAYLOAD, {6'd0, mx});
        write_reg(CFG_TIMEOUT, to);
        write_reg(CFG_SYNC_FIRST, {8'd0, sf});
        write_reg(CFG_SYNC_SECOND, {8'd0, ss});
    endtask

    task automatic push_item(input logic f, input logic [7:0] b);
        rx_item_t it;
        it.f = f;
        it.b = b;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_ticks(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    // one frame built from the current config; a truncated frame is left to time out
    task automatic add_frame(input logic [7:0] c, input logic [7:0] s, input logic [15:0] len,
                             input bit bad_crc, input bit trunc);
        logic [7:0]  frm[$];
        logic [15:0] crc;
        int          i;
        int          stop;
        int          idle_max;
        frm = {cfg_sf, cfg_ss, c, s, len[7:0], len[15:8]};
        if (int'(len) <= payload_cap())
        begin
            for (i = 0; i < int'(len); i++)
                frm.push_back(8'($urandom_range(0, 255)));
            crc = 16'hFFFF;
            for (i = 2; i < frm.size(); i++)
                crc = ccitt_update(crc, frm[i]);
            if (bad_crc)
                crc = crc ^ 16'($urandom_range(1, 65535));
            frm.push_back(crc[7:0]);
            frm.push_back(crc[15:8]);
        end
        stop = trunc ? $urandom_range(1, frm.size() - 1) : frm.size();
        idle_max = (cfg_timeout > 16'd5) ? 4 : int'(cfg_timeout) - 1;
        for (i = 0; i < stop; i++)
        begin
            // idle ticks between bytes, always short of the timeout
            if (i > 0 && idle_max > 0 && $urandom_range(0, 99) < 12)
                push_ticks($urandom_range(1, idle_max));
            push_item(FUNC_BYTE, frm[i]);
        end
        if (trunc)
            push_ticks(cfg_timeout);
    endtask

    // mostly well-formed frames, with broken frames and line noise mixed in
    task automatic add_traffic(input int n);
        int          start;
        int          sel;
        int          lim;
        int          i;
        logic [15:0] len;
        logic [7:0]  b;
        start = items_queued;
        lim = payload_cap();
        while (items_queued - start < n)
        begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                len = 16'($urandom_range(0, lim));
            else
                len = 16'($urandom_range(0, (lim < 12) ? lim : 12));
            if (sel < 70)
                add_frame(8'($urandom), 8'($urandom), len, sel >= 62, 1'b0);
            else if (sel < 77)
            begin
                // bad second sync, sometimes a repeated first sync
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1 && cfg_sf != cfg_ss)
                    b = cfg_sf;
                if (b == cfg_ss)
                    b = ~b;
                push_item(FUNC_BYTE, cfg_sf);
                push_item(FUNC_BYTE, b);
            end
            else if (sel < 84)
            begin
                if ($urandom_range(0, 3) == 0)
                    len = 16'hFFFF;
                else
                    len = 16'($urandom_range(lim + 1, lim + 700));
                add_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
            end
            else if (sel < 90 && cfg_timeout <= 16'd64)
                add_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b1);
            else
            begin
                // noise while hunting: ticks and bytes that are not a first sync
                for (i = 0; i < $urandom_range(1, 4); i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == cfg_sf)
                        b = ~b;
                    if ($urandom_range(0, 1) == 1)
                        push_item(FUNC_TICK, b);
                    else
                        push_item(FUNC_BYTE, b);
                end
            end
        end
    endtask

    // sender holds off until every item is taken and every result is back
    task automatic drain();
        int waited;
        waited = 0;
        while ((pending_items.size() != 0 || in_valid || expected_results.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            report_mismatch("results never delivered", 0, expected_results.size());
            expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender: bursts of random length with random gaps, payload held while stalled
    always @(negedge clk)
    begin : sender
        rx_item_t nxt;
        if (rst_n && (!in_valid || item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                in_valid <= 1'b1;
                func <= nxt.f;
                rx_byte <= nxt.b;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
        item_taken = 1'b0;
    end

    // receiver: stall pattern switches at random between free, light, heavy, runs
    always @(negedge clk)
    begin
        stall_cnt++;
        if (stall_cnt % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 25);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= stall_cnt[3];
        endcase
    end

    // monitor: check each delivered result, then predict from each accepted item
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected, kind", kind, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (kind != want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (data_byte != want.data_byte)
                        report_mismatch("data_byte", data_byte, want.data_byte);
                    if (position != want.position)
                        report_mismatch("position", position, want.position);
                    if (command != want.command)
                        report_mismatch("command", command, want.command);
                    if (sequence_res != want.sequence_res)
                        report_mismatch("sequence_res", sequence_res, want.sequence_res);
                    if (length != want.length)
                        report_mismatch("length", length, want.length);
                    if (reason != want.reason)
                        report_mismatch("reason", reason, want.reason);
                end
            end
            if (in_valid && !in_stall)
            begin
                deframe_step(func, rx_byte);
                item_taken = 1'b1;
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset, directed items first
        set_config(MAX_PAYLOAD_RST, TIMEOUT_RST, SYNC_FIRST_RST, SYNC_SECOND_RST);
        push_item(FUNC_TICK, 8'hFF);              // tick while hunting is ignored
        push_item(FUNC_BYTE, 8'h00);
        push_item(FUNC_BYTE, 8'hFF);
        push_item(FUNC_BYTE, cfg_sf);             // first sync repeated as second
        push_item(FUNC_BYTE, cfg_sf);
        add_frame(8'hFF, 8'h00, 16'd0, 1'b0, 1'b0);     // zero length, good crc
        add_frame(8'h00, 8'hFF, 16'd2, 1'b1, 1'b0);     // crc mismatch
        add_frame(8'hA5, 8'h5A, 16'hFFFF, 1'b0, 1'b0);  // too long, length saturates
        add_frame(8'h5A, 8'hA5, 16'd273, 1'b0, 1'b0);   // one past the limit
        drain();
        add_traffic(350);
        drain();

        // widest limit, timeout on the first tick, sync bytes at the extremes
        set_config(10'd512, 16'd1, 8'h00, 8'hFF);
        push_item(FUNC_BYTE, 8'h00);
        push_item(FUNC_BYTE, 8'hFF);
        push_item(FUNC_TICK, 8'h00);              // timeout before the length is known
        push_item(FUNC_BYTE, 8'h00);
        push_item(FUNC_BYTE, 8'hFF);
        push_item(FUNC_BYTE, 8'h01);
        push_item(FUNC_BYTE, 8'h02);
        push_item(FUNC_BYTE, 8'h03);
        push_item(FUNC_BYTE, 8'h00);
        push_item(FUNC_BYTE, 8'hAB);
        push_item(FUNC_TICK, 8'hFF);              // timeout inside the payload
        add_frame(8'h11, 8'h22, 16'd512, 1'b0, 1'b0);   // payload exactly at the limit
        add_frame(8'h33, 8'h44, 16'd513, 1'b0, 1'b0);
        drain();
        add_traffic(300);
        drain();

        // no payload allowed, longest timeout
        set_config(10'd0, 16'hFFFF, 8'hFF, 8'h00);
        add_traffic(250);
        drain();

        // both sync bytes equal, short timeout
        set_config(10'd100, 16'd3, 8'h5A, 8'h5A);
        add_traffic(300);
        drain();

        // a random setting
        set_config(10'($urandom_range(0, 512)), 16'($urandom_range(1, 40)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        add_traffic(300);
        drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/cfd_pkg.sv
design/cfd_cfg_regs.sv
design/cfd_parser.sv
design/cfd_out_buf.sv
design/crc16_frame_deframer.sv
dv/crc16_frame_deframer_tb.sv
